// File: hdl/dgad_pkg.sv
`default_nettype none

package dgad_pkg;

    localparam int CODE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int OFF_W   = 19;
    localparam int ROW_W   = 7;
    localparam int IDX_W   = 14;

    localparam logic [MODE_W-1:0] MODE_SBCS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJIS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EUC  = 2'd2;

    localparam logic [CODE_W-1:0] SJ_LEAD_A_LO  = 8'h81;
    localparam logic [CODE_W-1:0] SJ_LEAD_A_HI  = 8'h9f;
    localparam logic [CODE_W-1:0] SJ_LEAD_B_LO  = 8'he0;
    localparam logic [CODE_W-1:0] SJ_LEAD_B_HI  = 8'hfc;
    localparam logic [CODE_W-1:0] SJ_TRAIL_A_LO = 8'h40;
    localparam logic [CODE_W-1:0] SJ_TRAIL_A_HI = 8'h7e;
    localparam logic [CODE_W-1:0] SJ_TRAIL_B_LO = 8'h80;
    localparam logic [CODE_W-1:0] SJ_TRAIL_B_HI = 8'h9e;
    localparam logic [CODE_W-1:0] SJ_TRAIL_C_LO = 8'h9f;
    localparam logic [CODE_W-1:0] SJ_TRAIL_C_HI = 8'hfc;
    localparam logic [ROW_W-1:0]  SJ_ROW_B_BASE = 7'd62;
    localparam logic [ROW_W-1:0]  SJ_CELL_B_BASE = 7'd63;

    localparam logic [CODE_W-1:0] EUC_LEAD_LO = 8'h81;
    localparam logic [CODE_W-1:0] EUC_LEAD_HI = 8'hfe;
    localparam logic [CODE_W-1:0] EUC_BYTE_LO = 8'ha1;
    localparam logic [CODE_W-1:0] EUC_BYTE_HI = 8'hfe;

    localparam logic [IDX_W-1:0] CELLS_PER_ROW = 14'd94;
    localparam logic [OFF_W-1:0] WIDE_BASE     = 19'd4096;

    typedef struct packed {
        logic             font_select;
        logic [OFF_W-1:0] glyph_offset;
        logic             wide_glyph;
        logic             bad_code;
    } t_res;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] lead_nxt;
        t_res              res;
    } t_dec;

endpackage

`default_nettype wire

// File: hdl/dgad_decode.sv
`default_nettype none

module dgad_decode
    import dgad_pkg::*;
(
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [CODE_W-1:0] i_lead,
    input  wire logic [CODE_W-1:0] i_byte,
    output t_dec                   o_dec
);

    logic [CODE_W-1:0] lead_da;
    logic [CODE_W-1:0] lead_db;
    logic [CODE_W-1:0] byte_da;
    logic [CODE_W-1:0] byte_db;
    logic [CODE_W-1:0] byte_dc;
    logic [CODE_W-1:0] eu_lead_d;
    logic [CODE_W-1:0] eu_byte_d;
    logic [ROW_W-1:0]  sj_k;
    logic [ROW_W-1:0]  sj_t;
    logic              sj_ok;
    logic              eu_ok;
    logic              sj_lead_start;
    logic              eu_lead_start;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic              pair_ok;
    logic [IDX_W-1:0]  index;
    logic [OFF_W-1:0]  wide_off;
    logic [OFF_W-1:0]  single_off;

    assign lead_da   = i_lead - SJ_LEAD_A_LO;
    assign lead_db   = i_lead - SJ_LEAD_B_LO;
    assign byte_da   = i_byte - SJ_TRAIL_A_LO;
    assign byte_db   = i_byte - SJ_TRAIL_B_LO;
    assign byte_dc   = i_byte - SJ_TRAIL_C_LO;
    assign eu_lead_d = i_lead - EUC_BYTE_LO;
    assign eu_byte_d = i_byte - EUC_BYTE_LO;

    assign sj_lead_start = (i_byte >= SJ_LEAD_A_LO && i_byte <= SJ_LEAD_A_HI)
                        || (i_byte >= SJ_LEAD_B_LO && i_byte <= SJ_LEAD_B_HI);
    assign eu_lead_start = (i_byte >= EUC_LEAD_LO && i_byte <= EUC_LEAD_HI);

    always_comb begin
        sj_ok = 1'b1;
        sj_k  = '0;
        sj_t  = '0;
        if (i_lead >= SJ_LEAD_A_LO && i_lead <= SJ_LEAD_A_HI) begin
            sj_k = {lead_da[ROW_W-2:0], 1'b0};
        end else if (i_lead >= SJ_LEAD_B_LO && i_lead <= SJ_LEAD_B_HI) begin
            sj_k = {lead_db[ROW_W-2:0], 1'b0} + SJ_ROW_B_BASE;
        end else begin
            sj_ok = 1'b0;
        end
        if (i_byte >= SJ_TRAIL_A_LO && i_byte <= SJ_TRAIL_A_HI) begin
            sj_t = byte_da[ROW_W-1:0];
        end else if (i_byte >= SJ_TRAIL_B_LO && i_byte <= SJ_TRAIL_B_HI) begin
            sj_t = byte_db[ROW_W-1:0] + SJ_CELL_B_BASE;
        end else if (i_byte >= SJ_TRAIL_C_LO && i_byte <= SJ_TRAIL_C_HI) begin
            sj_t = byte_dc[ROW_W-1:0];
            sj_k = sj_k + 7'd1;
        end else begin
            sj_ok = 1'b0;
        end
    end

    assign eu_ok = (i_lead >= EUC_BYTE_LO && i_lead <= EUC_BYTE_HI)
                && (i_byte >= EUC_BYTE_LO && i_byte <= EUC_BYTE_HI);

    assign row     = (i_mode == MODE_SJIS) ? sj_k  : eu_lead_d[ROW_W-1:0];
    assign col     = (i_mode == MODE_SJIS) ? sj_t  : eu_byte_d[ROW_W-1:0];
    assign pair_ok = (i_mode == MODE_SJIS) ? sj_ok : eu_ok;

    assign index      = {{(IDX_W-ROW_W){1'b0}}, row} * CELLS_PER_ROW
                      + {{(IDX_W-ROW_W){1'b0}}, col};
    assign wide_off   = WIDE_BASE + {index, 5'd0};
    assign single_off = {{(OFF_W-CODE_W-4){1'b0}}, i_byte, 4'd0};

    always_comb begin
        o_dec                  = '0;
        o_dec.lead_nxt         = i_lead;
        o_dec.res.glyph_offset = single_off;
        unique case (i_mode)
            MODE_SBCS: begin
                o_dec.emit = 1'b1;
            end
            MODE_SJIS, MODE_EUC: begin
                if (i_lead == '0) begin
                    if ((i_mode == MODE_SJIS) ? sj_lead_start : eu_lead_start) begin
                        o_dec.lead_nxt = i_byte;
                    end else begin
                        o_dec.emit            = 1'b1;
                        o_dec.res.font_select = 1'b1;
                    end
                end else begin
                    o_dec.emit             = 1'b1;
                    o_dec.lead_nxt         = '0;
                    o_dec.res.font_select  = 1'b1;
                    o_dec.res.wide_glyph   = 1'b1;
                    o_dec.res.bad_code     = !pair_ok;
                    o_dec.res.glyph_offset = pair_ok ? wide_off : '0;
                end
            end
            default: begin
                o_dec.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/dbcs_glyph_address_decoder_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_code_byte
// result    out        o_valid / i_stall    o_font_select, o_glyph_offset,
//                                           o_wide_glyph, o_bad_code
// config    in         i_lang_mode_we       i_lang_mode
//
// One byte per cycle sustained while the result side does not stall; each byte is registered
// in the input register, then decoded into the result register, from which the result transfers.
// A lead byte is held in the lead register and gives no result.
// Synchronous active-low reset clears valids, the held lead and lang_mode.
// A stall on the result side holds the result register, then the input register.

module dbcs_glyph_address_decoder_unit
    import dgad_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_lang_mode_we,
    input  wire logic [MODE_W-1:0] i_lang_mode,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic [CODE_W-1:0] i_code_byte,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      logic              o_font_select,
    output      logic [OFF_W-1:0]  o_glyph_offset,
    output      logic              o_wide_glyph,
    output      logic              o_bad_code
);

    logic              r_in_vld;
    logic [CODE_W-1:0] r_in_byte;
    logic [CODE_W-1:0] r_lead;
    logic [MODE_W-1:0] r_mode;
    logic              r_out_vld;
    t_res              r_res;

    logic              out_free;
    logic              fire;
    logic              in_take;
    t_dec              dec;

    dgad_decode u_decode (
        .i_mode (r_mode),
        .i_lead (r_lead),
        .i_byte (r_in_byte),
        .o_dec  (dec)
    );

    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_lead    <= '0;
            r_mode    <= MODE_SBCS;
        end else begin
            if (i_lang_mode_we) begin
                r_mode <= i_lang_mode;
            end
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (fire) begin
                r_lead <= dec.lead_nxt;
            end
            if (out_free) begin
                r_out_vld <= fire && dec.emit;
            end
        end
        if (in_take) begin
            r_in_byte <= i_code_byte;
        end
        if (fire && dec.emit) begin
            r_res <= dec.res;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_font_select  = r_res.font_select;
    assign o_glyph_offset = r_res.glyph_offset;
    assign o_wide_glyph   = r_res.wide_glyph;
    assign o_bad_code     = r_res.bad_code;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_code |-> o_glyph_offset == '0 && o_wide_glyph && o_font_select)
        else $error("bad result with nonzero offset or narrow glyph");

    a_narrow_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wide_glyph |-> !o_bad_code)
        else $error("single-byte glyph flagged bad");

    a_wide_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wide_glyph && !o_bad_code |-> o_glyph_offset >= WIDE_BASE
            && o_glyph_offset[4:0] == 5'd0)
        else $error("wide glyph offset below base or misaligned");

    a_lead_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !dec.emit && (r_mode == MODE_SJIS || r_mode == MODE_EUC)
            |=> r_lead != '0 && !(r_out_vld && !$past(r_out_vld && i_stall)))
        else $error("lead byte not held or produced a result");

endmodule

`default_nettype wire

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dgad_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 400;
    localparam int REPORT_MAX    = 10;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_lang_mode_we = 1'b0;
    logic [MODE_W-1:0] i_lang_mode    = MODE_SBCS;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic [CODE_W-1:0] i_code_byte    = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic              o_font_select;
    logic [OFF_W-1:0]  o_glyph_offset;
    logic              o_wide_glyph;
    logic              o_bad_code;

    logic [CODE_W-1:0] text_q[$];
    t_res              glyph_q[$];

    logic [MODE_W-1:0] cur_mode  = MODE_SBCS;
    logic [CODE_W-1:0] held_lead = '0;

    bit byte_taken  = 1'b0;
    int fault_count = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_style = 0;
    int stall_left  = 0;

    dbcs_glyph_address_decoder_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lang_mode_we (i_lang_mode_we),
        .i_lang_mode    (i_lang_mode),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_byte    (i_code_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_font_select  (o_font_select),
        .o_glyph_offset (o_glyph_offset),
        .o_wide_glyph   (o_wide_glyph),
        .o_bad_code     (o_bad_code)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_res wide_glyph_at(input bit ok, input int row, input int col);
        t_res r;
        int   offs;
        r = '0;
        r.font_select = 1'b1;
        r.wide_glyph  = 1'b1;
        if (ok) begin
            offs = 4096 + (row * 94 + col) * 32;
            r.glyph_offset = offs[OFF_W-1:0];
        end else begin
            r.bad_code = 1'b1;
        end
        return r;
    endfunction

    function automatic bit predict_glyph(input logic [CODE_W-1:0] b, output t_res r);
        int lead;
        int row;
        int col;
        bit ok;
        r    = '0;
        lead = int'(held_lead);
        row  = 0;
        col  = 0;
        ok   = 1'b1;
        r.glyph_offset = OFF_W'({b, 4'b0000});
        if (cur_mode == MODE_SBCS) begin
            return 1'b1;
        end
        if (cur_mode == MODE_IDLE) begin
            return 1'b0;
        end
        r.font_select = 1'b1;
        if (cur_mode == MODE_SJIS) begin
            if (lead == 0) begin
                if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) begin
                    held_lead = b;
                    return 1'b0;
                end
                return 1'b1;
            end
            held_lead = '0;
            if (lead >= 'h81 && lead <= 'h9f) begin
                row = (lead - 'h81) * 2;
            end else if (lead >= 'he0 && lead <= 'hfc) begin
                row = (lead - 'he0) * 2 + 62;
            end else begin
                ok = 1'b0;
            end
            if (b >= 8'h40 && b <= 8'h7e) begin
                col = int'(b) - 'h40;
            end else if (b >= 8'h80 && b <= 8'h9e) begin
                col = int'(b) - 'h80 + 63;
            end else if (b >= 8'h9f && b <= 8'hfc) begin
                col = int'(b) - 'h9f;
                row = row + 1;
            end else begin
                ok = 1'b0;
            end
            r = wide_glyph_at(ok, row, col);
            return 1'b1;
        end
        if (lead == 0) begin
            if (b >= 8'h81 && b <= 8'hfe) begin
                held_lead = b;
                return 1'b0;
            end
            return 1'b1;
        end
        held_lead = '0;
        ok = (lead >= 'ha1 && lead <= 'hfe) && (b >= 8'ha1 && b <= 8'hfe);
        r  = wide_glyph_at(ok, ok ? lead - 'ha1 : 0, ok ? int'(b) - 'ha1 : 0);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        t_res pred;
        bit   in_xfer;
        bit   out_xfer;
        in_xfer  = i_valid && !o_stall;
        out_xfer = o_valid && !i_stall;
        byte_taken <= i_rst_n && in_xfer;
        if (!i_rst_n) begin
            cur_mode  = MODE_SBCS;
            held_lead = '0;
            idle_cycles <= 0;
        end else begin
            if (i_lang_mode_we) begin
                cur_mode = i_lang_mode;
            end
            if (out_xfer) begin
                got.font_select  = o_font_select;
                got.glyph_offset = o_glyph_offset;
                got.wide_glyph   = o_wide_glyph;
                got.bad_code     = o_bad_code;
                if (glyph_q.size() == 0) begin
                    if (fault_count < REPORT_MAX) begin
                        $display("%0t: unexpected result sel=%0d off=%0d wide=%0d bad=%0d",
                                 $time, got.font_select, got.glyph_offset,
                                 got.wide_glyph, got.bad_code);
                    end
                    fault_count++;
                end else begin
                    want = glyph_q.pop_front();
                    if (got.font_select !== want.font_select ||
                        got.glyph_offset !== want.glyph_offset ||
                        got.wide_glyph !== want.wide_glyph ||
                        got.bad_code !== want.bad_code) begin
                        if (fault_count < REPORT_MAX) begin
                            $display("%0t: mismatch want sel=%0d off=%0d wide=%0d bad=%0d",
                                     $time, want.font_select, want.glyph_offset,
                                     want.wide_glyph, want.bad_code);
                            $display("%0t:           got sel=%0d off=%0d wide=%0d bad=%0d",
                                     $time, got.font_select, got.glyph_offset,
                                     got.wide_glyph, got.bad_code);
                        end
                        fault_count++;
                    end
                end
            end
            if (in_xfer && predict_glyph(i_code_byte, pred)) begin
                glyph_q.push_back(pred);
            end
            idle_cycles <= (in_xfer || out_xfer) ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_valid || byte_taken) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (text_q.size() > 0) begin
                i_valid     <= 1'b1;
                i_code_byte <= text_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_left  = $urandom_range(40, 160);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_style)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                i_stall <= ((stall_left % 13) < 7);
            end
        endcase
    end

    task automatic load_lang_mode(input logic [MODE_W-1:0] m);
        @(negedge i_clk);
        i_lang_mode_we <= 1'b1;
        i_lang_mode    <= m;
        @(negedge i_clk);
        i_lang_mode_we <= 1'b0;
    endtask

    task automatic settle_pipeline();
        do begin
            @(posedge i_clk);
        end while (text_q.size() != 0 || i_valid || glyph_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(input logic [MODE_W-1:0] m, input int n);
        int                sent;
        int                pick;
        logic [CODE_W-1:0] lead;
        logic [CODE_W-1:0] trail;
        sent = 0;
        while (sent < n) begin
            pick  = $urandom_range(0, 19);
            lead  = $urandom_range(0, 255);
            trail = $urandom_range(0, 255);
            if (m == MODE_SJIS && pick < 15) begin
                lead = ($urandom_range(0, 1) != 0) ? $urandom_range(8'h81, 8'h9f)
                                                   : $urandom_range(8'he0, 8'hfc);
                if (pick < 13) begin
                    trail = ($urandom_range(0, 2) == 0) ? $urandom_range(8'h40, 8'h7e)
                                                        : $urandom_range(8'h80, 8'hfc);
                end else begin
                    case ($urandom_range(0, 2))
                        0: trail = $urandom_range(8'h00, 8'h3f);
                        1: trail = 8'h7f;
                        default: trail = $urandom_range(8'hfd, 8'hff);
                    endcase
                end
                text_q.push_back(lead);
                text_q.push_back(trail);
                sent += 2;
            end else if (m == MODE_SJIS && pick < 18) begin
                case ($urandom_range(0, 2))
                    0: lead = $urandom_range(8'h00, 8'h80);
                    1: lead = $urandom_range(8'ha0, 8'hdf);
                    default: lead = $urandom_range(8'hfd, 8'hff);
                endcase
                text_q.push_back(lead);
                sent += 1;
            end else if (m == MODE_EUC && pick < 15) begin
                lead  = $urandom_range(8'ha1, 8'hfe);
                trail = $urandom_range(8'ha1, 8'hfe);
                if (pick == 13) begin
                    lead = $urandom_range(8'h81, 8'ha0);
                    trail = $urandom_range(0, 255);
                end else if (pick == 14) begin
                    trail = ($urandom_range(0, 3) == 0) ? 8'hff : $urandom_range(8'h00, 8'ha0);
                end
                text_q.push_back(lead);
                text_q.push_back(trail);
                sent += 2;
            end else if (m == MODE_EUC && pick < 18) begin
                lead = ($urandom_range(0, 7) == 0) ? 8'hff : $urandom_range(8'h00, 8'h80);
                text_q.push_back(lead);
                sent += 1;
            end else begin
                text_q.push_back(lead);
                sent += 1;
            end
        end
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] m, input int n);
        load_lang_mode(m);
        queue_random(m, n);
        settle_pipeline();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_lang_mode(MODE_SBCS);
        text_q.push_back(8'h00);
        text_q.push_back(8'hff);
        settle_pipeline();

        load_lang_mode(MODE_SJIS);
        text_q.push_back(8'h41);
        text_q.push_back(8'h81); text_q.push_back(8'h40);
        text_q.push_back(8'hfc); text_q.push_back(8'hfc);
        text_q.push_back(8'he0); text_q.push_back(8'h80);
        text_q.push_back(8'h88); text_q.push_back(8'h3f);
        text_q.push_back(8'h88); text_q.push_back(8'h7f);
        text_q.push_back(8'h88); text_q.push_back(8'hfd);
        text_q.push_back(8'h85);
        settle_pipeline();

        // hold the lead across the mode change
        load_lang_mode(MODE_EUC);
        text_q.push_back(8'hb0);
        text_q.push_back(8'ha1); text_q.push_back(8'ha1);
        text_q.push_back(8'hfe); text_q.push_back(8'hfe);
        text_q.push_back(8'h81); text_q.push_back(8'ha5);
        text_q.push_back(8'hb0); text_q.push_back(8'h20);
        text_q.push_back(8'hff);
        text_q.push_back(8'ha5);
        settle_pipeline();

        load_lang_mode(MODE_IDLE);
        text_q.push_back(8'h41);
        settle_pipeline();

        load_lang_mode(MODE_SJIS);
        text_q.push_back(8'h50);
        settle_pipeline();

        run_phase(MODE_SJIS, 110);
        run_phase(MODE_EUC, 110);
        run_phase(MODE_SBCS, 50);
        run_phase(MODE_IDLE, 8);
        run_phase(MODE_EUC, 90);
        run_phase(MODE_SJIS, 90);
        run_phase(MODE_SBCS, 20);
        run_phase(MODE_SJIS, 80);

        if (fault_count == 0 && glyph_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/dgad_pkg.sv
hdl/dgad_decode.sv
hdl/dbcs_glyph_address_decoder_unit.sv
bench/tb.sv
